FILE: hdl/cdpa_pkg.sv
// cdpa_pkg: widths, mode codes and types for the complex dot-product accumulator.
// No dependencies; imported by complex_dot_product_accumulator_unit.
`timescale 1ns / 1ps

package cdpa_pkg;

    localparam int SAMPLE_W  = 16;              // Q1.15 sample width
    localparam int OPND_W    = SAMPLE_W + 1;    // room for negating -1.0
    localparam int PROD_W    = 2 * OPND_W;      // exact 17x17 signed product
    localparam int TERM_W    = PROD_W + 1;      // sum of two products
    localparam int ACC_W     = 50;              // signed complex accumulators
    localparam int NORM_W    = 49;              // unsigned norm accumulator
    localparam int IN_DATA_W = 4 * SAMPLE_W;    // packed input fields
    localparam int OUT_FLD_W = 2 * ACC_W + NORM_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_HERMITIAN = 2'd0,
        MODE_BILINEAR  = 2'd1,
        MODE_SELF      = 2'd2,
        MODE_UNUSED    = 2'd3
    } t_mode;

    // register index decoded from paddr (word address)
    localparam logic REG_PRODUCT_MODE = 1'b0;

    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [TERM_W-1:0] t_term;

endpackage

FILE: hdl/complex_dot_product_accumulator_unit.sv
// complex_dot_product_accumulator_unit: streaming complex MAC with conjugation modes.
// Depends on cdpa_pkg (widths, mode codes, operand types).
`timescale 1ns / 1ps

// Usage
// - Slave stream: one item per element pair. s_axis_tdata holds a_real, a_imag,
//   b_real, b_imag (Q1.15, lowest bits first); s_axis_tlast marks the last element
//   of a vector.
// - Master stream: one item per vector, sent when its last element has been
//   summed: sum_real, sum_imag (signed, Q.30) and norm_sum (unsigned), saturated.
// - APB register product_mode at byte 0: 0 Hermitian a*conj(b), 1 bilinear a*b,
//   2 self a*a (b ignored, imaginary part doubled), 3 behaves as 0. Write it only
//   while no vector is in flight.
// - Throughput: one item per cycle while the pipeline is not stalled. Pipeline:
//   input/operand register, product register (six 17x17 multipliers), term
//   register, then the saturating accumulators feed the output register. A last
//   item's result reaches the master side once it is loaded into the output register.
// - Stall: the pipeline only stops when a last item reaches the accumulators while
//   the previous result is still held and not taken; non-last items keep flowing
//   while a result waits.
// - Reset (i_rst_n low, synchronous): accumulators cleared, pipeline empty, no
//   result pending, product_mode back to Hermitian.
module complex_dot_product_accumulator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdpa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cdpa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cdpa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] a_real, [31:16] a_imag, [47:32] b_real, [63:48] b_imag
    input  logic [cdpa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,   // last_element
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [49:0] sum_real, [99:50] sum_imag, [148:100] norm_sum, [151:149] zero
    output logic [cdpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import cdpa_pkg::*;

    localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};

    // ---------------- configuration ----------------
    t_mode r_mode;
    logic  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRODUCT_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HERMITIAN;
        end else if (w_cfg_wr) begin
            r_mode <= t_mode'(pwdata[1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_PRODUCT_MODE) begin
            prdata[1:0] = r_mode;
        end
    end

    // ---------------- pipeline control ----------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic r_s1_last,  r_s2_last,  r_s3_last;
    logic w_stall, w_adv, w_accept, w_fin;

    // a finished vector can only leave once the output register is free
    assign w_stall  = r_s3_valid && r_s3_last && r_out_valid && !m_axis_tready;
    assign w_adv    = !w_stall;
    assign w_accept = s_axis_tvalid && w_adv;
    assign w_fin    = w_adv && r_s3_valid && r_s3_last;

    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // ---------------- stage 1: operand select ----------------
    // Every mode is a bilinear product a*b' with b' chosen here:
    // Hermitian b' = conj(b), self b' = a.
    t_opnd w_ar, w_ai, w_br, w_bi;
    t_opnd r_ar, r_ai, r_br, r_bi;

    always_comb begin
        w_ar = t_opnd'($signed(s_axis_tdata[15:0]));
        w_ai = t_opnd'($signed(s_axis_tdata[31:16]));
        w_br = t_opnd'($signed(s_axis_tdata[47:32]));
        w_bi = t_opnd'($signed(s_axis_tdata[63:48]));
        case (r_mode)
            MODE_BILINEAR: begin
            end
            MODE_SELF: begin
                w_br = w_ar;
                w_bi = w_ai;
            end
            default: begin
                w_bi = -w_bi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ar      <= w_ar;
            r_ai      <= w_ai;
            r_br      <= w_br;
            r_bi      <= w_bi;
            r_s1_last <= s_axis_tlast;
        end
    end

    // ---------------- stage 2: products ----------------
    t_prod r_p_arbr, r_p_aibi, r_p_aibr, r_p_arbi, r_p_arar, r_p_aiai;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_arbr  <= r_ar * r_br;
            r_p_aibi  <= r_ai * r_bi;
            r_p_aibr  <= r_ai * r_br;
            r_p_arbi  <= r_ar * r_bi;
            r_p_arar  <= r_ar * r_ar;
            r_p_aiai  <= r_ai * r_ai;
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------- stage 3: terms ----------------
    // products stay far below 2^50, so no term clamping is needed
    t_term r_t_real, r_t_imag, r_t_norm;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t_real  <= TERM_W'(r_p_arbr) - TERM_W'(r_p_aibi);
            r_t_imag  <= TERM_W'(r_p_aibr) + TERM_W'(r_p_arbi);
            r_t_norm  <= TERM_W'(r_p_arar) + TERM_W'(r_p_aiai);
            r_s3_last <= r_s2_last;
        end
    end

    // ---------------- accumulate and saturate ----------------
    logic signed [ACC_W-1:0]  r_acc_real, r_acc_imag;
    logic        [NORM_W-1:0] r_acc_norm;
    logic signed [ACC_W:0]    w_sum_real, w_sum_imag;
    logic        [NORM_W:0]   w_sum_norm;
    logic signed [ACC_W-1:0]  n_acc_real, n_acc_imag;
    logic        [NORM_W-1:0] n_acc_norm;

    always_comb begin
        w_sum_real = (ACC_W+1)'(r_acc_real) + (ACC_W+1)'(r_t_real);
        w_sum_imag = (ACC_W+1)'(r_acc_imag) + (ACC_W+1)'(r_t_imag);
        // norm term is never negative
        w_sum_norm = (NORM_W+1)'(r_acc_norm) + (NORM_W+1)'(r_t_norm[TERM_W-2:0]);

        if (w_sum_real > ACC_MAX)      n_acc_real = ACC_MAX[ACC_W-1:0];
        else if (w_sum_real < ACC_MIN) n_acc_real = ACC_MIN[ACC_W-1:0];
        else                           n_acc_real = w_sum_real[ACC_W-1:0];

        if (w_sum_imag > ACC_MAX)      n_acc_imag = ACC_MAX[ACC_W-1:0];
        else if (w_sum_imag < ACC_MIN) n_acc_imag = ACC_MIN[ACC_W-1:0];
        else                           n_acc_imag = w_sum_imag[ACC_W-1:0];

        n_acc_norm = w_sum_norm[NORM_W] ? {NORM_W{1'b1}} : w_sum_norm[NORM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_real <= '0;
            r_acc_imag <= '0;
            r_acc_norm <= '0;
        end else if (w_adv && r_s3_valid) begin
            if (r_s3_last) begin
                r_acc_real <= '0;
                r_acc_imag <= '0;
                r_acc_norm <= '0;
            end else begin
                r_acc_real <= n_acc_real;
                r_acc_imag <= n_acc_imag;
                r_acc_norm <= n_acc_norm;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            m_axis_tdata <= OUT_DATA_W'({n_acc_norm, n_acc_imag, n_acc_real});
        end
    end

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_last && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while finished vector is blocked");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (r_acc_real == '0 && r_acc_imag == '0 && r_acc_norm == '0))
        else $error("accumulators not cleared after last item");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_fin))
        else $error("result raised without a last item");

    a_pipe_moves_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule

FILE: dv/tb_complex_dot_product_accumulator_unit.sv
// tb_complex_dot_product_accumulator_unit: self-checking bench for the complex dot-product
// accumulator (APB mode register, slave element stream, master sum stream).
// Depends on cdpa_pkg and complex_dot_product_accumulator_unit.
`timescale 1ns / 1ps

module tb_complex_dot_product_accumulator_unit;

    import cdpa_pkg::*;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake or APB activity before giving up
    localparam int DRAIN_CYCLES = 8;     // extra wait after the last owed sum arrives
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for backpressure

    // byte address of product_mode: register index times 4
    localparam logic [APB_ADDR_W-1:0] ADDR_PRODUCT_MODE = {REG_PRODUCT_MODE, 2'b00};

    // one element pair as it travels on the slave stream
    typedef struct {
        logic signed [SAMPLE_W-1:0] a_re;
        logic signed [SAMPLE_W-1:0] a_im;
        logic signed [SAMPLE_W-1:0] b_re;
        logic signed [SAMPLE_W-1:0] b_im;
        logic                       last;
    } t_elem;

    // the three sums emitted at the end of a vector
    typedef struct {
        logic [ACC_W-1:0]  re;
        logic [ACC_W-1:0]  im;
        logic [NORM_W-1:0] nrm;
    } t_sum_rec;

    // Running model of the accumulators plus the queue of sums still owed by the block.
    class t_cdot_scoreboard;
        localparam longint SUM_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
        localparam longint SUM_MIN = -SUM_MAX - 1;

        t_mode       mode;
        longint      acc_re;
        longint      acc_im;
        longint      acc_nrm;
        t_sum_rec    pending_sums[$];
        int unsigned errors;

        function new();
            mode    = MODE_HERMITIAN;
            acc_re  = 0;
            acc_im  = 0;
            acc_nrm = 0;
            errors  = 0;
        endfunction

        function void set_mode(t_mode m);
            mode = m;
        endfunction

        static function longint clamp_sum(longint s, longint lo);
            if (s > SUM_MAX) return SUM_MAX;
            if (s < lo) return lo;
            return s;
        endfunction

        // Every product is exact at Q2.30; terms stay far below 2^50, so no term clamp is needed
        // and only the accumulators need saturating.
        function void accumulate_element(t_elem e);
            longint   ar, ai, br, bi, tr, ti, tn;
            t_sum_rec r;
            ar = longint'(e.a_re);
            ai = longint'(e.a_im);
            br = longint'(e.b_re);
            bi = longint'(e.b_im);
            case (mode)
                MODE_BILINEAR: begin
                    tr = ar * br - ai * bi;
                    ti = ai * br + ar * bi;
                end
                MODE_SELF: begin
                    // b ignored, cross term doubled
                    tr = ar * ar - ai * ai;
                    ti = 2 * ar * ai;
                end
                default: begin
                    // Hermitian; the unused code lands here too
                    tr = ar * br + ai * bi;
                    ti = ai * br - ar * bi;
                end
            endcase
            tn = ar * ar + ai * ai;
            acc_re  = clamp_sum(acc_re + tr, SUM_MIN);
            acc_im  = clamp_sum(acc_im + ti, SUM_MIN);
            acc_nrm = clamp_sum(acc_nrm + tn, 0);
            if (e.last) begin
                r.re  = acc_re[ACC_W-1:0];
                r.im  = acc_im[ACC_W-1:0];
                r.nrm = acc_nrm[NORM_W-1:0];
                pending_sums.push_back(r);
                acc_re  = 0;
                acc_im  = 0;
                acc_nrm = 0;
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 30) begin
                $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
            end
        endtask

        task check_sums(logic [ACC_W-1:0] re, logic [ACC_W-1:0] im, logic [NORM_W-1:0] nrm);
            t_sum_rec w;
            if (pending_sums.size() == 0) begin
                report("unexpected result", {14'b0, re}, 64'b0);
                return;
            end
            w = pending_sums.pop_front();
            if (re !== w.re) report("sum_real", {14'b0, re}, {14'b0, w.re});
            if (im !== w.im) report("sum_imag", {14'b0, im}, {14'b0, w.im});
            if (nrm !== w.nrm) report("norm_sum", {15'b0, nrm}, {15'b0, w.nrm});
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] a_real, [31:16] a_imag, [47:32] b_real, [63:48] b_imag
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;   // last_element
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [49:0] sum_real, [99:50] sum_imag, [148:100] norm_sum, rest zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_cdot_scoreboard sums = new();

    // sender burst state
    int burst_left = 0;

    // receiver state; hold_req is raised by the stimulus, consumed by the receiver
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int rx_style   = 0;
    int style_left = 0;

    int quiet_cycles = 0;

    complex_dot_product_accumulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- monitors
    // Every accepted element feeds the model; sums owed are queued on a last item.
    always @(posedge i_clk) begin : elem_mon
        t_elem e;
        e.a_re = s_axis_tdata[15:0];
        e.a_im = s_axis_tdata[31:16];
        e.b_re = s_axis_tdata[47:32];
        e.b_im = s_axis_tdata[63:48];
        e.last = s_axis_tlast;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sums.accumulate_element(e);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sums.check_sums(m_axis_tdata[ACC_W-1:0],
                            m_axis_tdata[2*ACC_W-1:ACC_W],
                            m_axis_tdata[2*ACC_W+NORM_W-1:2*ACC_W]);
        end
    end

    // Watchdog: any handshake or APB activity counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- receiver
    // Stall pattern changes at random intervals: always ready, mostly ready,
    // mostly stalled, or toggling. A hold request overrides it with a long hold-off.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    rx_style   = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 120);
                end
                style_left--;
                case (rx_style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    function automatic t_elem mk(int ar, int ai, int br, int bi, bit last);
        t_elem e;
        e.a_re = 16'(ar);
        e.a_im = 16'(ai);
        e.b_re = 16'(br);
        e.b_im = 16'(bi);
        e.last = last;
        return e;
    endfunction

    // Leans on the rails and on zero, otherwise full-range random.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // One item on the slave stream; bursts of random length with idle gaps between.
    task automatic push_item(input t_elem e);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e.b_im, e.b_re, e.a_im, e.a_re};
        s_axis_tlast  <= e.last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_random_vector(input int len);
        t_elem e;
        for (int k = 0; k < len; k++) begin
            e.a_re = pick_sample();
            e.a_im = pick_sample();
            e.b_re = pick_sample();
            e.b_im = pick_sample();
            e.last = (k == len - 1);
            push_item(e);
        end
    endtask

    // Stop sending, let every owed sum arrive, then let trailing items drain.
    task automatic end_phase();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sums.pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_product_mode(input t_mode m);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PRODUCT_MODE;
        pwdata  <= APB_DATA_W'(m);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sums.set_mode(m);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------------------------------------------------------- stimulus
    initial begin
        t_mode phase_mode;
        int    sent;
        int    len;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: Hermitian from reset, rails on every operand
        push_item(mk(-32768, -32768, -32768, -32768, 0));
        push_item(mk(32767, 32767, 32767, 32767, 0));
        push_item(mk(-32768, 32767, 32767, -32768, 1));
        push_item(mk(0, 0, 0, 0, 1));
        push_item(mk(-32768, 0, 0, -32768, 1));
        end_phase();

        // bilinear
        write_product_mode(MODE_BILINEAR);
        push_item(mk(-32768, -32768, -32768, 32767, 0));
        push_item(mk(32767, -32768, -32768, -32768, 1));
        push_item(mk(-1, 1, 1, -1, 1));
        end_phase();

        // self product: b carries junk that must not matter
        write_product_mode(MODE_SELF);
        push_item(mk(-32768, -32768, 12345, -777, 0));
        push_item(mk(-32768, 32767, -32768, 32767, 1));
        push_item(mk(32767, -32768, 0, 0, 1));
        end_phase();

        // unused code behaves as Hermitian
        write_product_mode(MODE_UNUSED);
        push_item(mk(-32768, -32768, 32767, 32767, 0));
        push_item(mk(1, -1, -32768, -32768, 1));
        end_phase();

        // Random phases, about 100 elements each, one setting per phase.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       phase_mode = MODE_BILINEAR;
                1:       phase_mode = MODE_SELF;
                2:       phase_mode = MODE_HERMITIAN;
                3:       phase_mode = MODE_UNUSED;
                default: phase_mode = t_mode'($urandom_range(0, 3));
            endcase
            write_product_mode(phase_mode);
            // second phase: receiver holds off while short vectors pile up
            if (p == 1) hold_req = 1'b1;
            sent = 0;
            while (sent < 100) begin
                if (p == 1) len = $urandom_range(1, 2);
                else if ($urandom_range(0, 4) == 0) len = 1;
                else if ($urandom_range(0, 3) == 0) len = $urandom_range(9, 30);
                else len = $urandom_range(2, 8);
                send_random_vector(len);
                sent += len;
            end
            end_phase();
        end

        if (sums.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/cdpa_pkg.sv
hdl/complex_dot_product_accumulator_unit.sv
dv/tb_complex_dot_product_accumulator_unit.sv
